@@ hdl/vrsd_pkg.sv @@
// Shared types, codes and helpers for the varint record stream decoder.
`default_nettype none

package vrsd_pkg;

  // Record field phases, in stream order
  typedef enum logic [3:0] {
    PH_OPCODE = 4'd0,
    PH_FLAGS  = 4'd1,
    PH_LOGN   = 4'd2,
    PH_DST    = 4'd3,
    PH_SRC1   = 4'd4,
    PH_SRC2   = 4'd5,
    PH_MOD    = 4'd6,
    PH_IMM    = 4'd7,
    PH_AUX    = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  // Flags byte bit positions
  localparam int unsigned FLG_SRC2 = 0;
  localparam int unsigned FLG_MOD  = 1;
  localparam int unsigned FLG_IMM  = 3;
  localparam int unsigned FLG_AUX  = 4;
  localparam int unsigned FLG_LOGN = 5;

  // Varint byte layout
  localparam logic [7:0] VARINT_PAYLOAD_MASK = 8'h7F;
  localparam int unsigned VARINT_CONT_BIT    = 7;
  localparam int unsigned VARINT_DIGIT_BITS  = 7;

  localparam int unsigned NUM_MAPS = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  flags;
    logic [7:0]  log_n;
    logic [31:0] dest_addr;
    logic [31:0] src_one;
    logic [31:0] src_two;
    logic [63:0] modulus_val;
    logic [63:0] immediate;
    logic [63:0] auxiliary;
    logic        status;
  } out_item_t;

  // First phase after cur that the record actually carries, or PH_DONE
  function automatic phase_t next_phase(input phase_t cur, input logic [7:0] flg,
                                        input logic has_ops);
    logic [8:0] need;
    phase_t     res;
    need = {flg[FLG_AUX], flg[FLG_IMM], flg[FLG_MOD], flg[FLG_SRC2],
            has_ops, has_ops, flg[FLG_LOGN], 2'b00};
    res  = PH_DONE;
    for (int q = 8; q >= 2; q--) begin
      if ((q > int'(cur)) && need[q]) begin
        res = phase_t'(4'(q));
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/vrsd_in_reg.sv @@
// Input holding register: takes one byte transfer per cycle, stalls when full and blocked.
`default_nettype none

module vrsd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vrsd_pkg::in_item_t in_data,
  input  wire logic              take,
  output logic                   held_valid,
  output vrsd_pkg::in_item_t     held_item
);
  import vrsd_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  // Full and not drained this cycle: hold off the sender
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

`default_nettype wire

@@ hdl/vrsd_field_decoder.sv @@
// Record field sequencer: varint accumulation, field capture and error detection per byte.
`default_nettype none

module vrsd_field_decoder #(
  parameter int unsigned MAX_VARINT_BYTES = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire vrsd_pkg::in_item_t    item,
  input  wire logic [3:0][63:0]      operand_map,
  output logic                       res_valid,
  output vrsd_pkg::out_item_t        res
);
  import vrsd_pkg::*;

  localparam logic [4:0] MAX_BYTES = 5'(MAX_VARINT_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        failed_r, failed_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  logn_r, logn_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic [31:0] src1_r, src1_nxt;
  logic [31:0] src2_r, src2_nxt;
  logic [63:0] mod_r, mod_nxt;
  logic [63:0] imm_r, imm_nxt;
  logic [63:0] aux_r, aux_nxt;

  logic        has_ops;
  logic [6:0]  payload;
  logic [6:0]  shamt;
  logic [63:0] acc_new;
  logic        err;
  logic        eos;
  logic [7:0]  byte_in;

  // Operand map lookup for the opcode of the current record
  assign has_ops = operand_map[opcode_r[7:6]][opcode_r[5:0]];

  assign byte_in = item.in_byte;
  assign eos     = item.end_of_stream;
  assign payload = 7'(byte_in & VARINT_PAYLOAD_MASK);
  assign shamt   = 7'(idx_r) * 7'(VARINT_DIGIT_BITS);
  assign acc_new = acc_r | (64'(payload) << shamt);

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    failed_nxt = failed_r;
    opcode_nxt = opcode_r;
    flags_nxt  = flags_r;
    logn_nxt   = logn_r;
    dest_nxt   = dest_r;
    src1_nxt   = src1_r;
    src2_nxt   = src2_r;
    mod_nxt    = mod_r;
    imm_nxt    = imm_r;
    aux_nxt    = aux_r;
    err        = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    if (failed_r) begin
      // Skip to end of stream after an error
      if (eos) begin
        phase_nxt  = PH_OPCODE;
        idx_nxt    = '0;
        acc_nxt    = '0;
        failed_nxt = 1'b0;
      end
    end else begin
      case (phase_r)
        PH_FLAGS: begin
          flags_nxt = byte_in;
          phase_nxt = next_phase(PH_FLAGS, byte_in, has_ops);
        end
        PH_LOGN: begin
          logn_nxt  = byte_in;
          phase_nxt = next_phase(PH_LOGN, flags_r, has_ops);
        end
        PH_DST, PH_SRC1, PH_SRC2, PH_MOD, PH_IMM, PH_AUX: begin
          if ((5'(idx_r) >= MAX_BYTES) || (idx_r > 4'd9)) begin
            err = 1'b1;
          end else if ((idx_r == 4'd9) && (payload[6:1] != '0)) begin
            // Payload beyond bit 63
            err = 1'b1;
          end else if (!byte_in[VARINT_CONT_BIT]) begin
            // Last byte of the varint: capture the field
            if (((phase_r == PH_DST) || (phase_r == PH_SRC1) || (phase_r == PH_SRC2)) &&
                (acc_new[63:32] != '0)) begin
              err = 1'b1;
            end else begin
              case (phase_r)
                PH_DST:  dest_nxt = acc_new[31:0];
                PH_SRC1: src1_nxt = acc_new[31:0];
                PH_SRC2: src2_nxt = acc_new[31:0];
                PH_MOD:  mod_nxt  = acc_new;
                PH_IMM:  imm_nxt  = acc_new;
                default: aux_nxt  = acc_new;
              endcase
              acc_nxt   = '0;
              idx_nxt   = '0;
              phase_nxt = next_phase(phase_r, flags_r, has_ops);
            end
          end else if ((5'(idx_r) + 5'd1) >= MAX_BYTES) begin
            // Varint too long
            err = 1'b1;
          end else begin
            idx_nxt = idx_r + 4'd1;
            acc_nxt = acc_new;
          end
        end
        default: begin
          // Opcode byte starts a fresh record
          opcode_nxt = byte_in;
          flags_nxt  = '0;
          logn_nxt   = '0;
          dest_nxt   = '0;
          src1_nxt   = '0;
          src2_nxt   = '0;
          mod_nxt    = '0;
          imm_nxt    = '0;
          aux_nxt    = '0;
          idx_nxt    = '0;
          acc_nxt    = '0;
          phase_nxt  = PH_FLAGS;
        end
      endcase

      // Completed record, or error / end of stream inside a record
      if (!err && (phase_nxt == PH_DONE)) begin
        res_valid       = 1'b1;
        res.opcode      = opcode_nxt;
        res.flags       = flags_nxt;
        res.log_n       = logn_nxt;
        res.dest_addr   = dest_nxt;
        res.src_one     = src1_nxt;
        res.src_two     = src2_nxt;
        res.modulus_val = mod_nxt;
        res.immediate   = imm_nxt;
        res.auxiliary   = aux_nxt;
        res.status      = 1'b0;
        phase_nxt       = PH_OPCODE;
        idx_nxt         = '0;
        acc_nxt         = '0;
      end else if (err || eos) begin
        res_valid  = 1'b1;
        res.status = 1'b1;
        phase_nxt  = PH_OPCODE;
        idx_nxt    = '0;
        acc_nxt    = '0;
        failed_nxt = !eos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      idx_r    <= '0;
      acc_r    <= '0;
      failed_r <= 1'b0;
      opcode_r <= '0;
      flags_r  <= '0;
      logn_r   <= '0;
      dest_r   <= '0;
      src1_r   <= '0;
      src2_r   <= '0;
      mod_r    <= '0;
      imm_r    <= '0;
      aux_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      acc_r    <= acc_nxt;
      failed_r <= failed_nxt;
      opcode_r <= opcode_nxt;
      flags_r  <= flags_nxt;
      logn_r   <= logn_nxt;
      dest_r   <= dest_nxt;
      src1_r   <= src1_nxt;
      src2_r   <= src2_nxt;
      mod_r    <= mod_nxt;
      imm_r    <= imm_nxt;
      aux_r    <= aux_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/vrsd_out_reg.sv @@
// Result register: holds one decoded record until the receiver takes it.
`default_nettype none

module vrsd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire vrsd_pkg::out_item_t load_item,
  output logic                     slot_free,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vrsd_pkg::out_item_t      out_data
);
  import vrsd_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // Empty, or emptying by a transfer this cycle
  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = item_r;

endmodule

`default_nettype wire

@@ hdl/varint_record_stream_decoder.sv @@
// LEB128 varint record stream decoder, top level.
//
// Bytes of the record section arrive on the in_ channel (in_valid / in_stall,
// payload in_data: byte plus end-of-stream mark). Each completed record, or a
// status-truncated error record, leaves on the out_ channel as one transfer.
// A byte transfer lands in an input register; the field decoder consumes it
// once the output register has room and writes any result there, so out_valid
// is registered. One byte is consumed per cycle, sustained while the receiver
// does not stall, set by the single pass through the field decoder. When the
// receiver stalls, the output register holds its record and the decoder waits;
// once the input register holds a byte, in_stall is raised in the same cycle
// as the blocking out_stall.
// The cfg_ write channel (always ready) loads the four 64-bit operand maps;
// write them only while the decoder sits between records.
// Reset (rst_n low, synchronous) clears the maps, empties both registers
// and returns the decoder to expecting an opcode.
`default_nettype none

module varint_record_stream_decoder #(
  parameter int unsigned MAX_VARINT_BYTES = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vrsd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vrsd_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata
);
  import vrsd_pkg::*;

  logic [3:0][63:0] map_r;
  logic             held_valid;
  in_item_t         held_item;
  logic             slot_free;
  logic             step;
  logic             res_valid;
  out_item_t        res;

  // Operand map registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      map_r[cfg_index] <= cfg_wdata;
    end
  end

  // A held byte is consumed when the result slot can take whatever it yields
  assign step = held_valid && slot_free;

  vrsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  vrsd_field_decoder #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (held_item),
    .operand_map (map_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  vrsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_item (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
